@@ rtl/css_whitespace_minifier_defines.svh @@
// Assertion helpers for the stylesheet whitespace minifier.
// Every check is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef CSS_WHITESPACE_MINIFIER_DEFINES_SVH
`define CSS_WHITESPACE_MINIFIER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cwm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared types and character codes for the stylesheet whitespace minifier.
// ----------------------------------------------------------------------------
package cwm_pkg;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Emit mask bits, lowest bit goes out first.
  localparam int unsigned EmitSpace  = 0;
  localparam int unsigned EmitBslash = 1;
  localparam int unsigned EmitSemi   = 2;
  localparam int unsigned EmitChar   = 3;
  localparam int unsigned EmitW      = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_t;

  typedef struct packed {
    logic pending_space;
    logic pending_semicolon;
    logic pending_backslash;
    logic after_comma;
    logic after_colon;
  } flags_t;

  // Bytes produced by one input: which held bytes are released, and the byte itself.
  typedef struct packed {
    logic [EmitW-1:0] mask;
    logic [7:0]       ch;
  } bundle_t;

endpackage

@@ rtl/cwm_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwm_step
// Decodes one byte against the held flags: next flags and the bytes to emit.
// ----------------------------------------------------------------------------
module cwm_step (
  input  wire cwm_pkg::flags_t flags_i,
  input  wire cwm_pkg::in_t    in_i,
  output cwm_pkg::flags_t      flags_o,
  output cwm_pkg::bundle_t     bundle_o
);

  logic [7:0]      c;
  cwm_pkg::flags_t nxt;
  logic            semi_held;

  assign c = in_i.in_byte;

  always_comb begin
    nxt           = flags_i;
    bundle_o.mask = '0;
    bundle_o.ch   = c;
    semi_held     = flags_i.pending_semicolon;

    if (c == cwm_pkg::CH_SPACE) begin
      // Drop the first space after a comma or colon, otherwise hold one.
      if (flags_i.after_comma) begin
        nxt.after_comma = 1'b0;
      end else if (flags_i.after_colon) begin
        nxt.after_colon = 1'b0;
      end else begin
        nxt.pending_space = 1'b1;
      end
    end else begin
      nxt.after_comma   = 1'b0;
      nxt.after_colon   = 1'b0;
      nxt.pending_space = 1'b0;
      bundle_o.mask[cwm_pkg::EmitSpace] = flags_i.pending_space &&
          !(c == cwm_pkg::CH_LBRACE || c == cwm_pkg::CH_GT || c == cwm_pkg::CH_PLUS);

      case (c)
        cwm_pkg::CH_NL: begin
          nxt.pending_backslash = 1'b0;
        end
        cwm_pkg::CH_TAB: begin
        end
        cwm_pkg::CH_SEMI: begin
          nxt.pending_semicolon = 1'b1;
        end
        cwm_pkg::CH_BSLASH: begin
          nxt.pending_backslash = 1'b1;
        end
        default: begin
          if (c == cwm_pkg::CH_COMMA) begin
            nxt.after_comma = 1'b1;
          end else if (c == cwm_pkg::CH_COLON) begin
            nxt.after_colon = 1'b1;
          end else if (c == cwm_pkg::CH_RBRACE) begin
            semi_held = 1'b0;
          end
          bundle_o.mask[cwm_pkg::EmitBslash] = flags_i.pending_backslash;
          bundle_o.mask[cwm_pkg::EmitSemi]   = semi_held;
          bundle_o.mask[cwm_pkg::EmitChar]   = 1'b1;
          nxt.pending_backslash = 1'b0;
          nxt.pending_semicolon = 1'b0;
        end
      endcase
    end

    // End of text discards everything held.
    if (in_i.end_of_text) begin
      nxt = '0;
    end
  end

  assign flags_o = nxt;

endmodule
`default_nettype wire

@@ rtl/css_whitespace_minifier.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// css_whitespace_minifier
// Streaming whitespace remover for stylesheet text, one byte in per cycle while in_stall_o is low.
// ----------------------------------------------------------------------------
// Each accepted input byte yields zero to four output bytes: a released space,
// a released backslash, a released semicolon and the byte itself, in that
// order, with run_last set on the last one. The input side takes one byte
// per cycle while in_stall_o is low; the bytes that one input emits leave
// through the single output port one at a time, so the sustained rate is
// set by the output port at one byte per cycle while out_stall_i is low.
// Between the decoder and the output sits a two-entry queue of decoded
// bundles, so the input keeps flowing while a finished byte waits on
// out_stall_i, and in_stall_o comes from a register only. Output bytes
// appear in the cycle after the input transfer at the earliest.
module css_whitespace_minifier (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire cwm_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output cwm_pkg::out_t     out_data_o
);

  // Held flags, updated on every input transfer.
  cwm_pkg::flags_t  flags_q, flags_d;
  cwm_pkg::bundle_t step_bundle;

  // Two-entry bundle queue.
  cwm_pkg::bundle_t fifo_q [2];
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_ptr_q, rd_ptr_q;

  logic                      in_xfer, push, out_xfer, pop;
  cwm_pkg::bundle_t          head;
  logic [cwm_pkg::EmitW-1:0] low_bit;
  logic                      head_last;

  cwm_step u_step (
    .flags_i  (flags_q),
    .in_i     (in_data_i),
    .flags_o  (flags_d),
    .bundle_o (step_bundle)
  );

  // Stall only when both entries are taken.
  assign in_stall_o = cnt_q[1];
  assign in_xfer    = in_valid_i && !in_stall_o;
  // Bundles with nothing to emit never enter the queue.
  assign push       = in_xfer && (step_bundle.mask != '0);

  // Head entry: emit the lowest remaining mask bit.
  assign head      = fifo_q[rd_ptr_q];
  assign low_bit   = head.mask & (~head.mask + {{(cwm_pkg::EmitW-1){1'b0}}, 1'b1});
  assign head_last = (head.mask & ~low_bit) == '0;

  assign out_valid_o = cnt_q != 2'd0;
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign pop         = out_xfer && head_last;

  always_comb begin
    out_data_o.run_last = head_last;
    case (low_bit)
      4'b0001: out_data_o.out_byte = cwm_pkg::CH_SPACE;
      4'b0010: out_data_o.out_byte = cwm_pkg::CH_BSLASH;
      4'b0100: out_data_o.out_byte = cwm_pkg::CH_SEMI;
      default: out_data_o.out_byte = head.ch;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        flags_q <= flags_d;
      end
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue payload. A push never lands on the head while it is being emitted.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= step_bundle;
    end
    if (out_xfer && !head_last) begin
      // Drop the byte just sent and keep the rest of the bundle at the head.
      fifo_q[rd_ptr_q].mask <= head.mask & ~low_bit;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cwm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwm_checker
// Port-level checks for the stylesheet whitespace minifier, bound to the top.
// ----------------------------------------------------------------------------
`include "css_whitespace_minifier_defines.svh"

module cwm_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire cwm_pkg::in_t  in_data_i,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input wire cwm_pkg::out_t out_data_o
);

  `CWM_ASSERT_SAME(a_idle_after_reset, $past(!rst_ni), !out_valid_o,
                   "output valid right after reset")
  `CWM_ASSERT_NEXT(a_hold_stalled, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_data_o), "stalled output transfer changed")
  `CWM_ASSERT_NEXT(a_run_continues, out_valid_o && !out_stall_i && !out_data_o.run_last,
                   out_valid_o, "run ended without run_last")
  `CWM_ASSERT_NEXT(a_space_silent,
                   in_valid_i && !in_stall_o && !out_valid_o &&
                   in_data_i.in_byte == cwm_pkg::CH_SPACE,
                   !out_valid_o, "space transfer emitted a byte")
  `CWM_ASSERT_NEXT(a_high_byte_kept,
                   in_valid_i && !in_stall_o && !out_valid_o && in_data_i.in_byte[7],
                   out_valid_o, "high byte transfer emitted nothing")

endmodule

bind css_whitespace_minifier cwm_checker u_cwm_checker (.*);
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the stylesheet whitespace minifier.
// ----------------------------------------------------------------------------
// Feeds stylesheet bytes through the input channel and predicts the minified
// bytes that each one releases. Every output transfer is compared field by
// field with the oldest predicted byte. The run covers hand-picked corner
// sequences, a long output hold-off that backs the block up to its input,
// and three random phases: fast sender with a busy receiver, the reverse,
// and both sides at full rate.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomItems  = 85;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  cwm_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  cwm_pkg::out_t out_data_o;

  // Predicted flags and the bytes still owed by the block, oldest first.
  cwm_pkg::flags_t minify_flags = '0;
  cwm_pkg::out_t   minified_q[$];
  int unsigned     fail_count = 0;

  // Idle rates in percent and the receiver hold-off, in cycles.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  css_whitespace_minifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one stylesheet byte to the flag model and queue the bytes it
  // releases: held space, held backslash, held semicolon, then the byte.
  function automatic void predict_minified(input cwm_pkg::in_t item);
    logic [7:0]    c;
    logic [7:0]    released[4];
    int            n;
    cwm_pkg::out_t r;
    c = item.in_byte;
    n = 0;
    if (c == cwm_pkg::CH_SPACE) begin
      // Swallow the first space after a comma or colon; hold any other.
      if (minify_flags.after_comma) begin
        minify_flags.after_comma = 1'b0;
      end else if (minify_flags.after_colon) begin
        minify_flags.after_colon = 1'b0;
      end else begin
        minify_flags.pending_space = 1'b1;
      end
    end else begin
      minify_flags.after_comma = 1'b0;
      minify_flags.after_colon = 1'b0;
      if (minify_flags.pending_space &&
          !(c == cwm_pkg::CH_LBRACE || c == cwm_pkg::CH_GT || c == cwm_pkg::CH_PLUS)) begin
        released[n] = cwm_pkg::CH_SPACE;
        n++;
      end
      minify_flags.pending_space = 1'b0;
      case (c)
        cwm_pkg::CH_NL: begin
          minify_flags.pending_backslash = 1'b0;
        end
        cwm_pkg::CH_TAB: begin
        end
        cwm_pkg::CH_SEMI: begin
          minify_flags.pending_semicolon = 1'b1;
        end
        cwm_pkg::CH_BSLASH: begin
          minify_flags.pending_backslash = 1'b1;
        end
        default: begin
          if (c == cwm_pkg::CH_COMMA) begin
            minify_flags.after_comma = 1'b1;
          end else if (c == cwm_pkg::CH_COLON) begin
            minify_flags.after_colon = 1'b1;
          end else if (c == cwm_pkg::CH_RBRACE) begin
            // A semicolon right before a closing brace is dead weight.
            minify_flags.pending_semicolon = 1'b0;
          end
          if (minify_flags.pending_backslash) begin
            minify_flags.pending_backslash = 1'b0;
            released[n] = cwm_pkg::CH_BSLASH;
            n++;
          end
          if (minify_flags.pending_semicolon) begin
            minify_flags.pending_semicolon = 1'b0;
            released[n] = cwm_pkg::CH_SEMI;
            n++;
          end
          released[n] = c;
          n++;
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      r.out_byte = released[i];
      r.run_last = (i == n - 1);
      minified_q.push_back(r);
    end
    // End of text drops whatever is still held.
    if (item.end_of_text) begin
      minify_flags = '0;
    end
  endfunction

  // Offer one byte, idling first at the sender's rate, and predict its
  // output once the transfer happens. Returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    cwm_pkg::in_t item;
    item.in_byte     = b;
    item.end_of_text = eot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_minified(item);
  endtask

  // Stop offering, wait for every owed byte, then let the pipe settle so a
  // stray extra byte still shows up as unexpected.
  task automatic wait_for_results();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (minified_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly stylesheet punctuation, spaces and letters, with raw bytes mixed
  // in so every bit of the byte toggles.
  function automatic logic [7:0] random_css_byte();
    logic [7:0]  specials[11] = '{cwm_pkg::CH_LBRACE, cwm_pkg::CH_GT, cwm_pkg::CH_PLUS,
                                  cwm_pkg::CH_SEMI, cwm_pkg::CH_COMMA, cwm_pkg::CH_COLON,
                                  cwm_pkg::CH_RBRACE, cwm_pkg::CH_BSLASH, cwm_pkg::CH_NL,
                                  cwm_pkg::CH_TAB, cwm_pkg::CH_SPACE};
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) begin
      return specials[$urandom_range(10)];
    end else if (roll < 60) begin
      return cwm_pkg::CH_SPACE;
    end else if (roll < 85) begin
      return 8'h61 + 8'($urandom_range(25));
    end
    return 8'($urandom_range(255));
  endfunction

  // Walk the corner cases: spaces after comma and colon, spaces before the
  // combinators and the opening brace, a space before a newline, a newline
  // cancelling a held backslash, all four held bytes released at once, a
  // semicolon lost to a closing brace, end of text dropping a held
  // semicolon, and the byte extremes.
  task automatic test_directed();
    logic [7:0] script[29] = '{cwm_pkg::CH_COMMA, cwm_pkg::CH_SPACE, "b", cwm_pkg::CH_COLON,
                               cwm_pkg::CH_SPACE, cwm_pkg::CH_SPACE, "c", cwm_pkg::CH_SPACE,
                               cwm_pkg::CH_LBRACE, cwm_pkg::CH_SPACE, cwm_pkg::CH_GT,
                               cwm_pkg::CH_SPACE, cwm_pkg::CH_PLUS, cwm_pkg::CH_SPACE,
                               cwm_pkg::CH_NL, cwm_pkg::CH_BSLASH, cwm_pkg::CH_NL, "d",
                               cwm_pkg::CH_BSLASH, cwm_pkg::CH_SEMI, cwm_pkg::CH_SPACE, "x",
                               cwm_pkg::CH_SEMI, cwm_pkg::CH_RBRACE, cwm_pkg::CH_SEMI, 8'h00,
                               cwm_pkg::CH_SPACE, cwm_pkg::CH_TAB, 8'hFF};
    send_idle_pct  = 10;
    recv_stall_pct = 30;
    foreach (script[i]) begin
      send_byte(script[i], (i == 24) || (i == $size(script) - 1));
    end
    wait_for_results();
  endtask

  // Hold the output off for a long stretch while the sender keeps offering
  // four-byte releases, so the bundle queue fills and stalls the input.
  // Then pause the sender until everything owed has drained.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 80;
    repeat (4) begin
      send_byte(cwm_pkg::CH_BSLASH, 1'b0);
      send_byte(cwm_pkg::CH_SEMI, 1'b0);
      send_byte(cwm_pkg::CH_SPACE, 1'b0);
      send_byte("y", 1'b0);
    end
    wait_for_results();
  endtask

  task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RandomItems) begin
      send_byte(random_css_byte(), $urandom_range(39) == 0);
    end
    wait_for_results();
  endtask

  // Check each output transfer against the oldest predicted byte, then pick
  // the stall for the next edge: a running hold-off wins over the random rate.
  always @(posedge clk_i) begin
    cwm_pkg::out_t owed;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (minified_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("%0t: unexpected output byte %h run_last %b",
                   $realtime, out_data_o.out_byte, out_data_o.run_last);
        end
      end else begin
        owed = minified_q.pop_front();
        if (out_data_o.out_byte !== owed.out_byte ||
            out_data_o.run_last !== owed.run_last) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("%0t: output mismatch: expected byte %h run_last %b, got byte %h run_last %b",
                     $realtime, owed.out_byte, owed.run_last,
                     out_data_o.out_byte, out_data_o.run_last);
          end
        end
      end
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end a hung run.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("css_whitespace_minifier verification failed");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random(10, 73);
    test_random(73, 10);
    test_random(0, 0);

    // Anything still owed after the drain never arrived.
    if (minified_q.size() != 0) begin
      fail_count += minified_q.size();
      $display("%0d predicted output bytes never arrived", minified_q.size());
    end
    if (fail_count == 0) begin
      $display("css_whitespace_minifier verification clean");
    end else begin
      $display("css_whitespace_minifier verification failed");
    end
    $finish;
  end

endmodule
